>>> hdl/rhbh_pkg.sv
// Shared types and constants for the RGB histogram block.
package rhbh_pkg;

    // Fixed field widths of the request and result transactions
    localparam int REQ_W   = 2;
    localparam int VALUE_W = 8;
    localparam int COUNT_W = 24;
    localparam int BAR_W   = 8;
    localparam int RGB_CH  = 3;

    // Request codes; the fourth code is a no-op
    typedef enum logic [REQ_W-1:0] {
        REQ_COUNT = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT_WR,
        S_RD_MUL,
        S_RD_INIT,
        S_RD_DIV,
        S_RD_OUT
    } t_state;

    // Operations the sequencer drives into every lane at once
    typedef struct packed {
        logic rd;    // latch address, read bin memory
        logic inc;   // write back saturated count, update peak
        logic clr;   // write zero at address, clear peak
        logic mul;   // scale count by bar height
        logic init;  // load divider
        logic step;  // one restoring division step
    } t_lane_cmd;

endpackage

>>> hdl/rhbh_lane.sv
// One channel lane: bin memory, peak tracker and bar height divider.
module rhbh_lane #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 24,
    parameter int BAR_HEIGHT = 256,
    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1,
    localparam int QB = $clog2(BAR_HEIGHT + 1),
    localparam int PW = COUNT_BITS + $clog2(BAR_HEIGHT)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rhbh_pkg::t_lane_cmd   i_cmd,
    input  logic [AW-1:0]         i_addr,
    input  logic                  i_hit,
    output logic [COUNT_BITS-1:0] o_count,
    output logic [QB-1:0]         o_bar
);
    import rhbh_pkg::*;

    logic [COUNT_BITS-1:0] r_mem [BINS];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [AW-1:0]         r_addr;
    logic                  r_hit;
    logic [COUNT_BITS-1:0] r_peak;
    logic [COUNT_BITS-1:0] r_count;
    logic [PW-1:0]         r_prod;
    logic [COUNT_BITS-1:0] r_rem;
    logic [QB-1:0]         r_num;
    logic [QB-1:0]         r_quo;

    logic [COUNT_BITS-1:0] n_count;
    logic [AW-1:0]         w_wr_addr;
    logic [COUNT_BITS:0]   w_trial;
    logic                  w_ge;

    // Saturating increment of the bin just read
    assign n_count   = (r_rdata == '1) ? r_rdata : r_rdata + 1'b1;
    assign w_wr_addr = i_cmd.clr ? i_addr : r_addr;

    // Shift in the next dividend bit and compare against the peak
    assign w_trial = {r_rem, r_num[QB-1]};
    assign w_ge    = (w_trial >= {1'b0, r_peak});

    // Bin memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || (i_cmd.inc && r_hit)) begin
            r_mem[w_wr_addr] <= i_cmd.clr ? '0 : n_count;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_addr];
            r_addr  <= i_addr;
            r_hit   <= i_hit;
        end
    end

    // Track the largest bin count of this channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (i_cmd.clr) begin
            r_peak <= '0;
        end else if (i_cmd.inc && r_hit && (n_count > r_peak)) begin
            r_peak <= n_count;
        end
    end

    // Scale, then divide by the peak one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_count <= r_rdata;
            r_prod  <= PW'(r_rdata) * PW'(BAR_HEIGHT);
        end
        if (i_cmd.init) begin
            r_rem <= COUNT_BITS'(r_prod >> QB);
            r_num <= r_prod[QB-1:0];
            r_quo <= '0;
        end else if (i_cmd.step) begin
            r_rem <= w_ge ? COUNT_BITS'(w_trial - {1'b0, r_peak}) : COUNT_BITS'(w_trial);
            r_num <= r_num << 1;
            r_quo <= {r_quo[QB-2:0], w_ge};
        end
    end

    // Empty histogram gives a zero bar; clamp the full-height case
    always_comb begin
        if (r_peak == '0) begin
            o_bar = '0;
        end else if (r_quo > QB'(BAR_HEIGHT - 1)) begin
            o_bar = QB'(BAR_HEIGHT - 1);
        end else begin
            o_bar = r_quo;
        end
    end

    assign o_count = r_count;

endmodule

>>> hdl/rhbh_merge.sv
// Result stage: combines lane results into one output transaction register.
module rhbh_merge #(
    parameter int NL         = 3,
    parameter int COUNT_BITS = 24,
    parameter int BAR_BITS   = 9
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  logic [rhbh_pkg::VALUE_W-1:0]     i_bin,
    input  logic                             i_bin_hit,
    input  logic [COUNT_BITS-1:0]            i_counts [NL],
    input  logic [BAR_BITS-1:0]              i_bars [NL],
    output logic                             o_free,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [rhbh_pkg::VALUE_W-1:0]     o_bin_index,
    output logic [rhbh_pkg::COUNT_W-1:0]     o_red_count,
    output logic [rhbh_pkg::COUNT_W-1:0]     o_green_count,
    output logic [rhbh_pkg::COUNT_W-1:0]     o_blue_count,
    output logic [rhbh_pkg::BAR_W-1:0]       o_red_bar,
    output logic [rhbh_pkg::BAR_W-1:0]       o_green_bar,
    output logic [rhbh_pkg::BAR_W-1:0]       o_blue_bar
);
    import rhbh_pkg::*;

    logic [COUNT_W-1:0] w_cnt [RGB_CH];
    logic [BAR_W-1:0]   w_bar [RGB_CH];
    logic               r_valid;
    logic [VALUE_W-1:0] r_bin;
    logic [COUNT_W-1:0] r_cnt [RGB_CH];
    logic [BAR_W-1:0]   r_bar [RGB_CH];

    // Absent lanes and out-of-range bins report zero
    for (genvar g = 0; g < RGB_CH; g++) begin : g_ch
        if (g < NL) begin : g_live
            assign w_cnt[g] = i_bin_hit ? COUNT_W'(i_counts[g]) : '0;
            assign w_bar[g] = i_bin_hit ? BAR_W'(i_bars[g]) : '0;
        end else begin : g_absent
            assign w_cnt[g] = '0;
            assign w_bar[g] = '0;
        end
    end

    assign o_free = !r_valid || i_ready;

    // Hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin <= i_bin;
            r_cnt <= w_cnt;
            r_bar <= w_bar;
        end
    end

    assign o_valid       = r_valid;
    assign o_bin_index   = r_bin;
    assign o_red_count   = r_cnt[0];
    assign o_green_count = r_cnt[1];
    assign o_blue_count  = r_cnt[2];
    assign o_red_bar     = r_bar[0];
    assign o_green_bar   = r_bar[1];
    assign o_blue_bar    = r_bar[2];

endmodule

>>> hdl/rgb_histogram_with_bar_heights_top.sv
// Per-channel 256-bin image histogram with bar heights, top level.
//
// Each request is one transaction; the block takes one at a time. A count
// request reads the bin, then does the saturating write-back and peak
// update, in all channel lanes side by side. A read request runs the
// one-bit-per-cycle restoring divider that forms count*BAR_HEIGHT/peak in
// each lane, then waits, if needed, for the result register to drain. A
// clear request clears one bin per cycle through the single write port of
// each lane memory. After reset the same clearing pass runs before the
// first request is taken.
module rgb_histogram_with_bar_heights_top #(
    parameter int BINS       = 256,
    parameter int LANES      = 3,
    parameter int COUNT_BITS = 24,
    parameter int BAR_HEIGHT = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [rhbh_pkg::REQ_W-1:0]        i_req_type,
    input  logic [rhbh_pkg::VALUE_W-1:0]      i_red_value,
    input  logic [rhbh_pkg::VALUE_W-1:0]      i_green_value,
    input  logic [rhbh_pkg::VALUE_W-1:0]      i_blue_value,
    input  logic [rhbh_pkg::VALUE_W-1:0]      i_read_bin,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [rhbh_pkg::VALUE_W-1:0]      o_bin_index,
    output logic [rhbh_pkg::COUNT_W-1:0]      o_red_count,
    output logic [rhbh_pkg::COUNT_W-1:0]      o_green_count,
    output logic [rhbh_pkg::COUNT_W-1:0]      o_blue_count,
    output logic [rhbh_pkg::BAR_W-1:0]        o_red_bar,
    output logic [rhbh_pkg::BAR_W-1:0]        o_green_bar,
    output logic [rhbh_pkg::BAR_W-1:0]        o_blue_bar
);
    import rhbh_pkg::*;

    localparam int IO_LANES = (LANES < RGB_CH) ? LANES : RGB_CH;
    localparam int AW       = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int QB       = $clog2(BAR_HEIGHT + 1);
    localparam int SW       = (QB > 1) ? $clog2(QB) : 1;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic [SW-1:0]      r_step, n_step;
    logic [VALUE_W-1:0] r_bin;
    logic               r_bin_hit;

    t_req               w_req;
    t_lane_cmd          w_cmd;
    logic               w_load;
    logic               w_out_free;
    logic               w_accept;
    logic [VALUE_W-1:0] w_samples [RGB_CH];
    logic [AW-1:0]      w_addr [IO_LANES];
    logic               w_hit [IO_LANES];
    logic [COUNT_BITS-1:0] w_lane_count [IO_LANES];
    logic [QB-1:0]      w_lane_bar [IO_LANES];

    assign w_req        = t_req'(i_req_type);
    assign w_accept     = i_valid && o_ready;
    assign w_samples[0] = i_red_value;
    assign w_samples[1] = i_green_value;
    assign w_samples[2] = i_blue_value;

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_step     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_step     <= n_step;
        end
    end

    // Next state and lane commands
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_step     = r_step;
        w_cmd      = '0;
        w_load     = 1'b0;
        o_ready    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clr  = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(BINS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (w_req)
                        REQ_COUNT: begin
                            w_cmd.rd = 1'b1;
                            n_state  = S_CNT_WR;
                        end
                        REQ_READ: begin
                            w_cmd.rd = 1'b1;
                            n_state  = S_RD_MUL;
                        end
                        REQ_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CNT_WR: begin
                w_cmd.inc = 1'b1;
                n_state   = S_IDLE;
            end
            S_RD_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_RD_INIT;
            end
            S_RD_INIT: begin
                w_cmd.init = 1'b1;
                n_step     = SW'(QB - 1);
                n_state    = S_RD_DIV;
            end
            S_RD_DIV: begin
                w_cmd.step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_RD_OUT;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_RD_OUT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Hold the requested bin for the result
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_req == REQ_READ)) begin
            r_bin     <= i_read_bin;
            r_bin_hit <= (32'(i_read_bin) < BINS);
        end
    end

    // Channel lanes
    for (genvar g = 0; g < IO_LANES; g++) begin : g_lane
        always_comb begin
            if (r_state == S_CLEAR) begin
                w_addr[g] = r_clr_addr;
            end else if (w_req == REQ_READ) begin
                w_addr[g] = AW'(i_read_bin);
            end else begin
                w_addr[g] = AW'(w_samples[g]);
            end
        end
        assign w_hit[g] = (32'(w_samples[g]) < BINS);

        rhbh_lane #(
            .BINS       (BINS),
            .COUNT_BITS (COUNT_BITS),
            .BAR_HEIGHT (BAR_HEIGHT)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_addr  (w_addr[g]),
            .i_hit   (w_hit[g]),
            .o_count (w_lane_count[g]),
            .o_bar   (w_lane_bar[g])
        );
    end

    // Merge lane results into the output register
    rhbh_merge #(
        .NL         (IO_LANES),
        .COUNT_BITS (COUNT_BITS),
        .BAR_BITS   (QB)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_bin         (r_bin),
        .i_bin_hit     (r_bin_hit),
        .i_counts      (w_lane_count),
        .i_bars        (w_lane_bar),
        .o_free        (w_out_free),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_bin_index   (o_bin_index),
        .o_red_count   (o_red_count),
        .o_green_count (o_green_count),
        .o_blue_count  (o_blue_count),
        .o_red_bar     (o_red_bar),
        .o_green_bar   (o_green_bar),
        .o_blue_bar    (o_blue_bar)
    );

endmodule
